### hdl/b32h_pkg.sv
// Shared types, constants and helpers for the base32hex stream encoder.
// No dependencies; imported by every module of the encoder.
package b32h_pkg;

  // ASCII codes used by the extended-hex alphabet and padding
  localparam logic [6:0] CHAR_ZERO = 7'h30;  // '0'
  localparam logic [6:0] CHAR_A    = 7'h41;  // 'A'
  localparam logic [6:0] CHAR_PAD  = 7'h3D;  // '='

  localparam int unsigned SYMBOLS_PER_GROUP = 8;
  localparam int unsigned BYTES_PER_GROUP   = 5;
  localparam int unsigned QUEUE_DEPTH_DEF   = 4;

  // One classified input byte, as handed from front end to back end
  typedef struct packed {
    logic [2:0][4:0] sym;        // 5-bit symbol values, sym[0] goes out first
    logic [1:0]      sym_count;  // symbols in use, 1..3
    logic [3:0]      pad_count;  // '=' characters after the symbols, 0..7
    logic            last;       // flag the final byte of the message
  } b32h_job_t;

  // Map a 5-bit value onto '0'..'9','A'..'V'
  function automatic logic [6:0] sym_char(input logic [4:0] v);
    logic [6:0] ch;
    if (v < 5'd10) begin
      ch = CHAR_ZERO + {2'b00, v};
    end else begin
      ch = CHAR_A + {2'b00, v} - 7'd10;
    end
    return ch;
  endfunction

  // Characters of a group completed after the byte at each position
  function automatic logic [3:0] chars_done(input logic [2:0] pos);
    logic [3:0] n;
    unique case (pos)
      3'd0:    n = 4'd1;
      3'd1:    n = 4'd3;
      3'd2:    n = 4'd4;
      3'd3:    n = 4'd6;
      3'd4:    n = 4'd8;
      default: n = 4'd1;
    endcase
    return n;
  endfunction

endpackage

### hdl/b32h_front.sv
// Front end of the base32hex encoder: accepts bytes, slices them into symbols
// and works out padding. Holds the leftover bits and group position.
// Depends on b32h_pkg.
module b32h_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       data_byte,
  input  logic             final_byte,
  input  logic             q_full,
  output logic             push,
  output b32h_pkg::b32h_job_t job
);
  import b32h_pkg::*;

  logic [3:0]  spare_bits,  spare_bits_next;
  logic [2:0]  spare_count, spare_count_next;
  logic [2:0]  group_position, group_position_next;

  logic [2:0]  cnt;
  logic [2:0]  pos;
  logic [11:0] acc;
  logic [3:0]  total;
  logic [3:0]  rem1;
  logic [3:0]  rem2;
  logic        two;
  logic [3:0]  rem;
  logic [3:0]  left_bits;
  logic [4:0]  tail_sym;
  logic        extra;
  logic [3:0]  in_group;

  // Stall only on a full queue
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Slice the byte behind the leftover bits into 5-bit symbols
  always_comb begin
    cnt       = (spare_count > 3'd4) ? 3'd4 : spare_count;
    pos       = (group_position > 3'd4) ? 3'd0 : group_position;
    acc       = {spare_bits, data_byte};
    total     = {1'b0, cnt} + 4'd8;
    rem1      = total - 4'd5;
    two       = (total >= 4'd10);
    rem2      = total - 4'd10;
    rem       = two ? rem2 : rem1;
    left_bits = 4'(acc & ((12'd1 << rem) - 12'd1));
    tail_sym  = 5'({1'b0, left_bits} << (4'd5 - rem));
    extra     = final_byte && (rem != 4'd0);
    in_group  = chars_done(pos) + {3'b000, extra};

    job.sym[0] = 5'(acc >> rem1);
    job.sym[1] = two ? 5'(acc >> rem2) : tail_sym;
    job.sym[2] = tail_sym;
    job.sym_count = 2'd1 + {1'b0, two} + {1'b0, extra};
    job.pad_count = (final_byte && (in_group < 4'd8)) ? (4'd8 - in_group) : 4'd0;
    job.last      = final_byte;
  end

  // Advance or clear the carried state
  always_comb begin
    spare_bits_next     = spare_bits;
    spare_count_next    = spare_count;
    group_position_next = group_position;
    if (push) begin
      if (final_byte) begin
        spare_bits_next     = 4'd0;
        spare_count_next    = 3'd0;
        group_position_next = 3'd0;
      end else begin
        spare_bits_next     = left_bits;
        spare_count_next    = rem[2:0];
        group_position_next = (pos >= 3'(BYTES_PER_GROUP - 1)) ? 3'd0 : pos + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spare_bits     <= 4'd0;
      spare_count    <= 3'd0;
      group_position <= 3'd0;
    end else begin
      spare_bits     <= spare_bits_next;
      spare_count    <= spare_count_next;
      group_position <= group_position_next;
    end
  end

endmodule

### hdl/b32h_queue.sv
// Short queue of classified bytes between front and back end.
// Depends on b32h_pkg for the entry type.
module b32h_queue #(
  parameter int unsigned DEPTH = b32h_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  b32h_pkg::b32h_job_t push_job,
  input  logic                pop,
  output b32h_pkg::b32h_job_t head_job,
  output logic                full,
  output logic                empty
);
  import b32h_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  b32h_job_t     entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign empty    = (count == '0);
  assign full     = (count == CW'(DEPTH));
  assign head_job = entries[rd_ptr];

  // Store the pushed beat
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Advance pointers, wrapping at the last slot, and track the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/b32h_back.sv
// Back end of the base32hex encoder (uses b32h_pkg): walks the head queue
// entry one character per cycle, unless stalled, into a registered output.
module b32h_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  b32h_pkg::b32h_job_t head_job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [6:0]          out_char,
  output logic                end_of_text
);
  import b32h_pkg::*;

  logic [2:0] step, step_next;
  logic [3:0] chars;
  logic       last_char;
  logic       emit;
  logic       is_sym;
  logic [4:0] sym_val;
  logic [6:0] char_next;

  // Pick the character at the current step
  always_comb begin
    chars     = {2'b00, head_job.sym_count} + head_job.pad_count;
    last_char = ({1'b0, step} == chars - 4'd1);
    is_sym    = (step < {1'b0, head_job.sym_count});
    case (step[1:0])
      2'd0:    sym_val = head_job.sym[0];
      2'd1:    sym_val = head_job.sym[1];
      default: sym_val = head_job.sym[2];
    endcase
    char_next = is_sym ? sym_char(sym_val) : CHAR_PAD;
    emit      = !q_empty && (!out_valid || !out_stall);
    pop       = emit && last_char;
    step_next = step;
    if (emit) begin
      step_next = last_char ? 3'd0 : step + 3'd1;
    end
  end

  // Hold the step counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the output beat
  always_ff @(posedge clk) begin
    if (emit) begin
      out_char    <= char_next;
      end_of_text <= head_job.last && last_char;
    end
  end

endmodule

### hdl/base32hex_stream_encoder_top.sv
// Base32hex stream encoder: one message byte per input beat, with final_byte
// marking the last byte; one ASCII character per output beat, end_of_text on
// the last one. The output side sends one character per cycle while out_stall
// is low; a plain byte yields one or two characters (1.6 on average, eight
// characters per five bytes) and the final byte up to eight including '='
// padding. The front end accepts a byte every cycle while the queue has room;
// its characters go from the QUEUE_DEPTH-entry queue to the registered output.
// Depends on b32h_pkg, b32h_front, b32h_queue and b32h_back.
module base32hex_stream_encoder_top #(
  parameter int unsigned QUEUE_DEPTH = b32h_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_char,
  output logic       end_of_text
);
  import b32h_pkg::*;

  b32h_job_t push_job;
  b32h_job_t head_job;
  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_empty;

  b32h_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .q_full     (q_full),
    .push       (push),
    .job        (push_job)
  );

  b32h_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  b32h_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .head_job    (head_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char    (out_char),
    .end_of_text (end_of_text)
  );

`ifndef NO_ASSERTIONS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("queue popped while empty");

  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty))
    else $error("queue full and empty at once");

  a_rise_needs_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!q_empty))
    else $error("output beat without a queued byte");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> (in_valid && !in_stall))
    else $error("queue written without an accepted beat");
`endif

endmodule
